/* hdl/fbt_pkg.sv */
// ----------------------------------------------------------------------------
// fbt_pkg
// Shared codes and result type for the flow block table.
// ----------------------------------------------------------------------------
package fbt_pkg;

  localparam int unsigned POS_W = 11;

  localparam logic [1:0] FN_BLOCK   = 2'd0;
  localparam logic [1:0] FN_UNBLOCK = 2'd1;
  localparam logic [1:0] FN_QUERY   = 2'd2;
  localparam logic [1:0] FN_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [POS_W-1:0] match_position;
    logic [POS_W-1:0] entries_now;
  } res_t;

endpackage

/* hdl/flow_block_table.sv */
// ----------------------------------------------------------------------------
// flow_block_table
// Unsorted table of blocked (source, destination) pairs: block, unblock,
// query and clear, with a one-compare-per-cycle linear search.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  in      | func, source, destination                 | in_valid / in_stall
//  out     | status, found, match_position, entries_now | out_valid / out_stall
//
//  One item at a time. Block, query and unblock scan the stored pairs through
//  the single memory read port, one compare per cycle; an unblock that hits
//  then moves the last entry into the freed slot. Clear skips the scan.
//  Synchronous reset empties the table at once (no clearing pass).
//  in_stall stays high from accept until the result is handed to the output
//  register; that register holds its beat while out_stall is high.
// ----------------------------------------------------------------------------
module flow_block_table #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [31:0]               source,
  input  logic [31:0]               destination,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic                      found,
  output logic [fbt_pkg::POS_W-1:0] match_position,
  output logic [fbt_pkg::POS_W-1:0] entries_now
);
  import fbt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic          idle;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  assign in_stall = !idle;

  fbt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fbt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .idle        (idle),
    .func        (func),
    .source      (source),
    .destination (destination),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  fbt_oreg u_oreg (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found          (found),
    .match_position (match_position),
    .entries_now    (entries_now)
  );

endmodule

/* hdl/fbt_mem.sv */
// ----------------------------------------------------------------------------
// fbt_mem
// Pair storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fbt_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/fbt_ctrl.sv */
// ----------------------------------------------------------------------------
// fbt_ctrl
// Sequencer: linear scan with one pair compare per cycle, then append,
// swap-remove or report; clear empties the table without a scan.
// ----------------------------------------------------------------------------
module fbt_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned AW       = 10,
  parameter int unsigned CW       = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               idle,
  input  logic [1:0]         func,
  input  logic [31:0]        source,
  input  logic [31:0]        destination,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [63:0]        rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [63:0]        wr_data,
  output logic               res_valid,
  output fbt_pkg::res_t      res,
  input  logic               res_ready
);
  import fbt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] scan_idx;
  logic          chk_vld;
  logic [AW-1:0] chk_idx;
  logic [CW-1:0] pos;
  logic [1:0]    op;
  logic [63:0]   key;

  logic          hit;
  logic          more;
  logic [CW-1:0] last;
  logic [CW-1:0] pos_m1;
  logic          full;

  assign hit    = chk_vld && (rd_data == key);
  assign more   = scan_idx < count;
  assign last   = count - CW'(1);
  assign pos_m1 = pos - CW'(1);
  assign full   = count >= CAP;
  assign idle   = state == S_IDLE;
  assign res_valid = state == S_DONE;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = key;
    case (state)
      S_SCAN: begin
        rd_en = !hit && more;
      end
      S_ACT: begin
        if (op == FN_BLOCK) begin
          wr_en = !full;
        end else if (op == FN_UNBLOCK) begin
          rd_en   = pos != '0;
          rd_addr = last[AW-1:0];
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = pos_m1[AW-1:0];
        wr_data = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      chk_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= func;
            key      <= {source, destination};
            scan_idx <= '0;
            chk_vld  <= 1'b0;
            if (func == FN_CLEAR) begin
              count <= '0;
              res   <= '{status: ST_OK, found: 1'b0, match_position: '0, entries_now: '0};
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            pos     <= CW'(chk_idx) + CW'(1);
            chk_vld <= 1'b0;
            state   <= S_ACT;
          end else if (more) begin
            chk_vld  <= 1'b1;
            chk_idx  <= scan_idx[AW-1:0];
            scan_idx <= scan_idx + CW'(1);
          end else begin
            pos     <= '0;
            chk_vld <= 1'b0;
            state   <= S_ACT;
          end
        end
        S_ACT: begin
          if (op == FN_BLOCK && full) begin
            res   <= '{status: ST_FULL, found: pos != '0,
                       match_position: POS_W'(pos), entries_now: POS_W'(count)};
            state <= S_DONE;
          end else if (op == FN_BLOCK) begin
            count <= count + CW'(1);
            res   <= '{status: ST_OK, found: pos != '0,
                       match_position: POS_W'(pos),
                       entries_now: POS_W'(count + CW'(1))};
            state <= S_DONE;
          end else if (op == FN_UNBLOCK && pos == '0) begin
            res   <= '{status: ST_ABSENT, found: 1'b0,
                       match_position: '0, entries_now: POS_W'(count)};
            state <= S_DONE;
          end else if (op == FN_UNBLOCK) begin
            res   <= '{status: ST_OK, found: 1'b1,
                       match_position: POS_W'(pos), entries_now: POS_W'(count)};
            state <= S_MOVE;
          end else begin
            res   <= '{status: ST_OK, found: pos != '0,
                       match_position: POS_W'(pos), entries_now: POS_W'(count)};
            state <= S_DONE;
          end
        end
        S_MOVE: begin
          count           <= last;
          res.entries_now <= POS_W'(last);
          state           <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/fbt_oreg.sv */
// ----------------------------------------------------------------------------
// fbt_oreg
// Output register for result beats; holds under stall.
// ----------------------------------------------------------------------------
module fbt_oreg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     res_valid,
  input  fbt_pkg::res_t            res,
  output logic                     res_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic                     found,
  output logic [fbt_pkg::POS_W-1:0] match_position,
  output logic [fbt_pkg::POS_W-1:0] entries_now
);
  import fbt_pkg::*;

  res_t hold;

  assign res_ready      = !out_valid || !out_stall;
  assign status         = hold.status;
  assign found          = hold.found;
  assign match_position = hold.match_position;
  assign entries_now    = hold.entries_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      hold <= res;
    end
  end

endmodule

/* hdl/fbt_check.sv */
// ----------------------------------------------------------------------------
// fbt_check
// Port-level checks for the flow block table, bound to the top level.
// ----------------------------------------------------------------------------
module fbt_check #(
  parameter int unsigned CAPACITY = 1024
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                status,
  input logic                      found,
  input logic [fbt_pkg::POS_W-1:0] match_position,
  input logic [fbt_pkg::POS_W-1:0] entries_now
);
  import fbt_pkg::*;

  localparam logic [POS_W-1:0] CAP_W = POS_W'(CAPACITY);

  a_rst_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("fbt: not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found)
      && $stable(match_position) && $stable(entries_now))
    else $error("fbt: stalled result beat changed");

  a_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_ABSENT |-> !found && match_position == '0)
    else $error("fbt: absent status with a match");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entries_now == CAP_W)
    else $error("fbt: full status below capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("fbt: accepted a second beat while busy");

endmodule

bind flow_block_table fbt_check #(.CAPACITY(CAPACITY)) u_fbt_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .found          (found),
  .match_position (match_position),
  .entries_now    (entries_now)
);

/* tb/sv/tb_flow_block_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_block_table
// Self-checking bench for the blocked-pair table. A tracker class mirrors the
// pair table, predicts status, hit, slot and count for every accepted command
// beat, and compares each result beat in order. Stimulus: directed corner
// commands, random traffic on a small table under three idle mixes, and an
// output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_flow_block_table;
  import fbt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned SMALL_TABLE = 48;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES = 1100;
  localparam int unsigned REPORT_MAX = 10;

  class pair_table_tracker;
    logic [31:0] src_words [TABLE_DEPTH];
    logic [31:0] dst_words [TABLE_DEPTH];
    int unsigned stored;
    res_t        awaited [$];
    int unsigned error_count;

    function new();
      stored = 0;
      error_count = 0;
    endfunction

    function void log_mismatch(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function res_t apply_command(logic [1:0] f, logic [31:0] s, logic [31:0] d);
      res_t        r;
      int unsigned hit;
      int unsigned i;
      r = '0;
      hit = 0;
      r.status = ST_OK;
      if (f == FN_CLEAR) begin
        stored = 0;
      end else begin
        for (i = 0; i < stored && hit == 0; i++) begin
          if (src_words[i] == s && dst_words[i] == d) hit = i + 1;
        end
        if (f == FN_BLOCK) begin
          if (stored >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            src_words[stored] = s;
            dst_words[stored] = d;
            stored++;
          end
        end else if (f == FN_UNBLOCK) begin
          if (hit == 0) begin
            r.status = ST_ABSENT;
          end else begin
            src_words[hit-1] = src_words[stored-1];
            dst_words[hit-1] = dst_words[stored-1];
            stored--;
          end
        end
      end
      r.found = (hit != 0);
      r.match_position = POS_W'(hit);
      r.entries_now = POS_W'(stored);
      return r;
    endfunction

    function void note_command(logic [1:0] f, logic [31:0] s, logic [31:0] d);
      awaited.push_back(apply_command(f, s, d));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat st=%0d fd=%0d pos=%0d cnt=%0d",
                               got.status, got.found, got.match_position, got.entries_now));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.match_position !== want.match_position ||
          got.entries_now !== want.entries_now) begin
        log_mismatch($sformatf(
          "exp st=%0d fd=%0d pos=%0d cnt=%0d, got st=%0d fd=%0d pos=%0d cnt=%0d",
          want.status, want.found, want.match_position, want.entries_now,
          got.status, got.found, got.match_position, got.entries_now));
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          func;
  logic [31:0]         source;
  logic [31:0]         destination;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          status;
  logic                found;
  logic [POS_W-1:0]    match_position;
  logic [POS_W-1:0]    entries_now;

  pair_table_tracker   board;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  logic                long_hold_req;
  int unsigned         quiet_cycles;

  flow_block_table #(.CAPACITY(TABLE_DEPTH)) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .source         (source),
    .destination    (destination),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found          (found),
    .match_position (match_position),
    .entries_now    (entries_now)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall, plus one long hold-off on request
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : out_monitor
    res_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {status, found, match_position, entries_now};
      board.check_result(got);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("flow_block_table verification failed");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [1:0] f, input logic [31:0] s, input logic [31:0] d);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    source <= s;
    destination <= d;
    do @(posedge clk); while (in_stall);
    board.note_command(f, s, d);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    logic [1:0]  f;
    logic [31:0] s;
    logic [31:0] d;
    int unsigned pick;
    int unsigned slot;
    int unsigned k;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 38) f = FN_BLOCK;
      else if (pick < 62) f = FN_UNBLOCK;
      else if (pick < 94) f = FN_QUERY;
      else f = FN_CLEAR;
      if (f == FN_BLOCK && board.stored >= SMALL_TABLE)
        f = ($urandom_range(3) == 0) ? FN_CLEAR : FN_UNBLOCK;
      s = $urandom;
      d = $urandom;
      pick = $urandom_range(99);
      if (board.stored != 0 && pick < 75) begin
        slot = $urandom_range(board.stored - 1);
        s = board.src_words[slot];
        d = board.dst_words[slot];
        // near miss: one address bit off
        if (pick >= 60) begin
          if ($urandom_range(1)) s ^= 32'd1 << $urandom_range(31);
          else d ^= 32'd1 << $urandom_range(31);
        end
      end else if (pick >= 90) begin
        s = $urandom_range(3);
        d = $urandom_range(3);
      end
      send_command(f, s, d);
    end
  endtask

  initial begin : main
    int unsigned k;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    func = FN_BLOCK;
    source = '0;
    destination = '0;
    long_hold_req = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 7;
    recv_idle_pct = 80;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_command(FN_QUERY,   32'h0000_1234, 32'h0000_5678);
    send_command(FN_UNBLOCK, 32'h0000_0000, 32'h0000_0000);
    send_command(FN_BLOCK,   32'h0000_0000, 32'h0000_0000);
    send_command(FN_BLOCK,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(FN_BLOCK,   32'h0000_0000, 32'h0000_0000);
    send_command(FN_QUERY,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(FN_QUERY,   32'h0000_0000, 32'hFFFF_FFFF);
    send_command(FN_QUERY,   32'hFFFF_FFFF, 32'h0000_0000);
    send_command(FN_UNBLOCK, 32'h0000_0000, 32'h0000_0000);
    send_command(FN_QUERY,   32'h0000_0000, 32'h0000_0000);
    send_command(FN_UNBLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(FN_UNBLOCK, 32'h0000_0000, 32'h0000_0000);
    send_command(FN_UNBLOCK, 32'h0000_0000, 32'h0000_0000);
    send_command(FN_BLOCK,   32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_command(FN_CLEAR,   $urandom,      $urandom);
    send_command(FN_QUERY,   32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_command(FN_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(FN_BLOCK,   32'h8000_0000, 32'h0000_0001);
    send_command(FN_BLOCK,   32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send_command(FN_UNBLOCK, 32'h8000_0000, 32'h0000_0001);
    send_command(FN_QUERY,   32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send_command(FN_CLEAR,   32'h0000_0000, 32'h0000_0000);

    run_random(180);
    drain_results();

    send_idle_pct = 80;
    recv_idle_pct = 7;
    run_random(190);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // output held off while the sender keeps offering beats
    long_hold_req = 1'b1;
    for (k = 0; k < 6; k++) send_command(FN_QUERY, $urandom, $urandom);
    run_random(190);
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.awaited.size() != 0)
      board.log_mismatch($sformatf("%0d results never arrived", board.awaited.size()));
    if (board.error_count == 0) begin
      $display("flow_block_table verification clean");
    end else begin
      $display("flow_block_table verification failed");
    end
    $finish;
  end

endmodule
